// ===== sv/current_sense_average_autorange_top_macros.svh =====
// Assertion macros shared by the current sense averaging block.
`ifndef CURRENT_SENSE_AVERAGE_AUTORANGE_TOP_MACROS_SVH
`define CURRENT_SENSE_AVERAGE_AUTORANGE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSA_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csa_auto same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CSA_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csa_auto next-cycle check failed");

`endif

// ===== sv/csa_auto_pkg.sv =====
// Types, widths and constants of the current sense averaging block.
`timescale 1ns / 1ps
package csa_auto_pkg;

   localparam int SAMPLES_PER_BLOCK_DEFAULT = 50;
   localparam int CAL_ENTRIES_DEFAULT       = 1024;

   localparam int SAMPLE_W  = 16;
   localparam int SUM_W     = 22;
   localparam int DAC_W     = 12;
   localparam int IDX_W     = 11;
   localparam int CALIDX_W  = 10;
   localparam int CAL_W     = 16;
   localparam int GAIN_W    = 32;
   localparam int OFFSET_W  = 21;
   localparam int THRESH_W  = 26;
   localparam int NA_W      = 27;
   localparam int DIFF_W    = 17;
   localparam int PROD_W    = 50;
   localparam int RND_W     = 34;
   localparam int RAW_W     = 35;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 88;

   localparam logic signed [RAW_W-1:0] RAW_NA_MAX = 35'sd67108863;
   localparam logic signed [RAW_W-1:0] RAW_NA_MIN = -35'sd67108864;

   localparam logic [GAIN_W-1:0]   HIGH_GAIN_RESET = 32'd20432814;
   localparam logic [GAIN_W-1:0]   LOW_GAIN_RESET  = 32'd114285;
   localparam logic [OFFSET_W-1:0] HIGH_OFFSET_RESET = 21'd15000;
   localparam logic [THRESH_W-1:0] THRESH_RESET    = 26'd100000;
   localparam logic [DAC_W-1:0]    DAC_MAX_RESET   = 12'd4095;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BYPASS_ON      = 3'd0,
      CSR_DAC_MIN_CODE   = 3'd1,
      CSR_DAC_MAX_CODE   = 3'd2,
      CSR_DAC_TABLE_BASE = 3'd3,
      CSR_HIGH_GAIN_Q16  = 3'd4,
      CSR_LOW_GAIN_Q16   = 3'd5,
      CSR_HIGH_OFFSET_NA = 3'd6,
      CSR_SWITCH_THRESH  = 3'd7
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE    = 1'b0,
      OP_CAL_WRITE = 1'b1
   } op_type;

endpackage

// ===== sv/current_sense_average_autorange_top.sv =====
// Averaging two-range current sense with calibration table and auto-ranging.
`timescale 1ns / 1ps
`include "current_sense_average_autorange_top_macros.svh"
// Accepts one item per cycle whenever the five-stage result pipeline has room: a sample
// pair (req_tuser op = 0) accumulates into the high and low channel sums, a calibration
// write (op = 1) stores one {high, low} zero reference into the table memory. Every
// SAMPLES_PER_BLOCK sample pairs the block closes: the last pair issues the table read
// at index (dac_code - dac_table_base) >> 1, and the result is formed in order by the memory
// read, the reciprocal multiply that averages, the gain multiply, the rounding and
// offset add, and the range decision. A new block may close while earlier results are
// still in the pipeline. Uncalibrated DAC codes give zero high and dut currents, a zero
// low current unless bypassed, with the uncalibrated flag set. No clearing pass is run;
// table entries must be written before a block that reads them closes.
module current_sense_average_autorange_top
   import csa_auto_pkg::*;
#(
   parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEFAULT,
   parameter int CAL_ENTRIES       = CAL_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration write port
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // high_sample, low_sample, dac_code, cal_index, cal_high_value, cal_low_value
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // op
   input  logic [0:0]             req_tuser,
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // dut_current_na, high_current_na, low_current_na
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // range_is_low, uncalibrated
   output logic [1:0]             rsp_tuser
);

   localparam int CNT_W   = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
   localparam int DIV_SH  = $clog2(SAMPLES_PER_BLOCK);
   localparam int RECIP_W = SUM_W + 1;
   localparam int QPROD_W = SUM_W + RECIP_W;
   localparam int Q_LSB   = SUM_W + DIV_SH;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << (SUM_W + DIV_SH)) / SAMPLES_PER_BLOCK) + 64'd1);
   localparam int CAL_AW  = $clog2(CAL_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_BLOCK - 1);

   // ---------------- configuration registers ----------------
   logic                bypass_ff;
   logic [DAC_W-1:0]    dac_min_ff, dac_max_ff, dac_base_ff;
   logic [GAIN_W-1:0]   high_gain_ff, low_gain_ff;
   logic [OFFSET_W-1:0] high_offset_ff;
   logic [THRESH_W-1:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff      <= 1'b1;
         dac_min_ff     <= '0;
         dac_max_ff     <= DAC_MAX_RESET;
         dac_base_ff    <= '0;
         high_gain_ff   <= HIGH_GAIN_RESET;
         low_gain_ff    <= LOW_GAIN_RESET;
         high_offset_ff <= HIGH_OFFSET_RESET;
         thresh_ff      <= THRESH_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BYPASS_ON:      bypass_ff      <= csr_wdata[0];
            CSR_DAC_MIN_CODE:   dac_min_ff     <= csr_wdata[DAC_W-1:0];
            CSR_DAC_MAX_CODE:   dac_max_ff     <= csr_wdata[DAC_W-1:0];
            CSR_DAC_TABLE_BASE: dac_base_ff    <= csr_wdata[DAC_W-1:0];
            CSR_HIGH_GAIN_Q16:  high_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_LOW_GAIN_Q16:   low_gain_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_HIGH_OFFSET_NA: high_offset_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_SWITCH_THRESH:  thresh_ff      <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- request field unpacking ----------------
   logic [SAMPLE_W-1:0] req_high, req_low;
   logic [DAC_W-1:0]    req_dac;
   logic [CALIDX_W-1:0] req_cal_index;
   logic [CAL_W-1:0]    req_cal_high, req_cal_low;
   op_type              req_op;

   assign req_high      = req_tdata[15:0];
   assign req_low       = req_tdata[31:16];
   assign req_dac       = req_tdata[43:32];
   assign req_cal_index = req_tdata[53:44];
   assign req_cal_high  = req_tdata[69:54];
   assign req_cal_low   = req_tdata[85:70];
   assign req_op        = op_type'(req_tuser[0]);

   // ---------------- pipeline flow control ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic out_free, s4_free, s3_free, s2_free, s1_free;

   // A stage takes new content when empty or when its content moves on.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s4_free  = !s4_valid_ff || out_free;
   assign s3_free  = !s3_valid_ff || s4_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;

   assign req_tready = s1_free;

   logic accept, is_sample, is_last;
   assign accept    = req_tvalid && req_tready;
   assign is_sample = accept && (req_op == OP_SAMPLE);

   // ---------------- accumulation (stage 0) ----------------
   logic [SUM_W-1:0] high_sum_ff, low_sum_ff, high_sum_in, low_sum_in;
   logic [CNT_W-1:0] cnt_ff;

   // Signed sample + 32768 is the sample with its top bit flipped.
   assign high_sum_in = high_sum_ff + SUM_W'({~req_high[SAMPLE_W-1], req_high[SAMPLE_W-2:0]});
   assign low_sum_in  = low_sum_ff + SUM_W'({~req_low[SAMPLE_W-1], req_low[SAMPLE_W-2:0]});
   assign is_last     = is_sample && (cnt_ff == CNT_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         high_sum_ff <= '0;
         low_sum_ff  <= '0;
         cnt_ff      <= '0;
      end else if (is_sample) begin
         if (cnt_ff == CNT_LAST) begin
            high_sum_ff <= '0;
            low_sum_ff  <= '0;
            cnt_ff      <= '0;
         end else begin
            high_sum_ff <= high_sum_in;
            low_sum_ff  <= low_sum_in;
            cnt_ff      <= cnt_ff + CNT_W'(1);
         end
      end
   end

   // ---------------- calibration window and table index ----------------
   logic [DAC_W-1:0] dac_rel;
   logic [IDX_W-1:0] cal_rd_idx, cal_wr_idx;
   logic             uncal;

   assign dac_rel    = req_dac - dac_base_ff;
   assign cal_rd_idx = dac_rel[DAC_W-1:1];
   assign cal_wr_idx = IDX_W'(req_cal_index);
   assign uncal      = (req_dac >= dac_max_ff) || (req_dac < dac_min_ff) ||
                       (req_dac < dac_base_ff) || (32'(cal_rd_idx) >= 32'(CAL_ENTRIES));

   // ---------------- calibration memory ----------------
   logic [2*CAL_W-1:0] cal_mem [0:CAL_ENTRIES-1];
   logic [2*CAL_W-1:0] cal_rd_ff;
   logic               cal_we;

   assign cal_we = accept && (req_op == OP_CAL_WRITE) && (32'(cal_wr_idx) < 32'(CAL_ENTRIES));

   // Low half holds the low channel, high half the high channel.
   always_ff @(posedge clock) begin
      if (cal_we) begin
         cal_mem[cal_wr_idx[CAL_AW-1:0]] <= {req_cal_high, req_cal_low};
      end
      if (is_last) begin
         cal_rd_ff <= cal_mem[cal_rd_idx[CAL_AW-1:0]];
      end
   end

   // ---------------- stage 1: closed sums ----------------
   logic [SUM_W-1:0] s1_hsum_ff, s1_lsum_ff;
   logic             s1_uncal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= is_last;
      end
      if (is_last) begin
         s1_hsum_ff  <= high_sum_in;
         s1_lsum_ff  <= low_sum_in;
         s1_uncal_ff <= uncal;
      end
   end

   // ---------------- stage 2: average by reciprocal multiply ----------------
   logic [QPROD_W-1:0] s2_hq_ff, s2_lq_ff;
   logic [2*CAL_W-1:0] s2_cal_ff;
   logic               s2_uncal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_free && s1_valid_ff) begin
         s2_hq_ff    <= QPROD_W'(s1_hsum_ff) * QPROD_W'(RECIP);
         s2_lq_ff    <= QPROD_W'(s1_lsum_ff) * QPROD_W'(RECIP);
         s2_cal_ff   <= cal_rd_ff;
         s2_uncal_ff <= s1_uncal_ff;
      end
   end

   // ---------------- stage 3: subtract zero reference, apply gain ----------------
   logic [CAL_W-1:0]         h_avg, l_avg;
   logic signed [DIFF_W-1:0] h_diff, l_diff;
   logic signed [PROD_W-1:0] s3_hp_ff, s3_lp_ff;
   logic                     s3_uncal_ff;

   assign h_avg  = s2_hq_ff[Q_LSB +: CAL_W];
   assign l_avg  = s2_lq_ff[Q_LSB +: CAL_W];
   assign h_diff = $signed({1'b0, h_avg}) - $signed({1'b0, s2_cal_ff[2*CAL_W-1:CAL_W]});
   assign l_diff = $signed({1'b0, l_avg}) - $signed({1'b0, s2_cal_ff[CAL_W-1:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_free && s2_valid_ff) begin
         s3_hp_ff    <= h_diff * $signed({1'b0, high_gain_ff});
         s3_lp_ff    <= l_diff * $signed({1'b0, low_gain_ff});
         s3_uncal_ff <= s2_uncal_ff;
      end
   end

   // ---------------- stage 4: round, offset, clamp low ----------------
   function automatic logic signed [NA_W-1:0] sat_na(input logic signed [RAW_W-1:0] v);
      logic signed [RAW_W-1:0] c;
      begin
         if (v > RAW_NA_MAX) begin
            c = RAW_NA_MAX;
         end else if (v < RAW_NA_MIN) begin
            c = RAW_NA_MIN;
         end else begin
            c = v;
         end
         return c[NA_W-1:0];
      end
   endfunction

   logic signed [PROD_W-1:0] h_rnd_full, l_rnd_full;
   logic signed [RND_W-1:0]  h_rnd, l_rnd;
   logic signed [RAW_W-1:0]  h_raw, l_raw;
   logic signed [RAW_W-1:0]  s4_high_raw_ff;
   logic signed [NA_W-1:0]   s4_low_na_ff;
   logic                     s4_uncal_ff;

   // Round half up: add one half, then floor by arithmetic shift.
   assign h_rnd_full = s3_hp_ff + PROD_W'(32768);
   assign l_rnd_full = s3_lp_ff + PROD_W'(32768);
   assign h_rnd      = h_rnd_full[PROD_W-1:16];
   assign l_rnd      = l_rnd_full[PROD_W-1:16];
   assign h_raw      = $signed({h_rnd[RND_W-1], h_rnd}) +
                       $signed({{(RAW_W-OFFSET_W){high_offset_ff[OFFSET_W-1]}}, high_offset_ff});
   assign l_raw      = $signed({l_rnd[RND_W-1], l_rnd});

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_free) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (s4_free && s3_valid_ff) begin
         // drop to zero, offset included, outside the calibrated window
         s4_high_raw_ff <= s3_uncal_ff ? '0 : h_raw;
         s4_low_na_ff   <= s3_uncal_ff ? '0 : sat_na(l_raw);
         s4_uncal_ff    <= s3_uncal_ff;
      end
   end

   // ---------------- output stage: range decision ----------------
   logic                   range_low_ff, range_low_in;
   logic signed [NA_W-1:0] held_low_ff, held_low_in;
   logic signed [NA_W-1:0] high_na;
   logic signed [NA_W-1:0] rsp_dut_ff, rsp_high_ff, rsp_low_ff;
   logic                   rsp_range_ff, rsp_uncal_ff;
   logic                   s4_adv;

   assign s4_adv  = s4_valid_ff && out_free;
   assign high_na = sat_na(s4_high_raw_ff);

   always_comb begin
      range_low_in = range_low_ff;
      held_low_in  = held_low_ff;
      if (bypass_ff) begin
         range_low_in = 1'b0;
      end else if (s4_high_raw_ff <= $signed({{(RAW_W-THRESH_W){1'b0}}, thresh_ff})) begin
         range_low_in = 1'b1;
         held_low_in  = s4_low_na_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         range_low_ff <= 1'b0;
         held_low_ff  <= '0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= s4_valid_ff;
         end
         if (s4_adv) begin
            range_low_ff <= range_low_in;
            held_low_ff  <= held_low_in;
         end
      end
      if (s4_adv) begin
         rsp_dut_ff   <= range_low_in ? held_low_in : high_na;
         rsp_high_ff  <= high_na;
         rsp_low_ff   <= held_low_in;
         rsp_range_ff <= range_low_in;
         rsp_uncal_ff <= s4_uncal_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-3*NA_W){1'b0}}, rsp_low_ff, rsp_high_ff, rsp_dut_ff};
   assign rsp_tuser  = {rsp_uncal_ff, rsp_range_ff};

   // ---------------- checks ----------------
   `CSA_ASSERT_NXT(a_close_enters_pipe, clock, reset, is_last, s1_valid_ff)
   `CSA_ASSERT_IMP(a_rsp_from_stage4, clock, reset, $rose(rsp_valid_ff), $past(s4_valid_ff))
   `CSA_ASSERT_IMP(a_uncal_zero_high, clock, reset, rsp_valid_ff && rsp_uncal_ff, rsp_high_ff == '0)
   `CSA_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, cnt_ff <= CNT_LAST)

endmodule

// ===== dv/tb_current_sense_average_autorange_top.sv =====
// Self-checking testbench for the averaging two-range current sense block.
`timescale 1ns / 1ps
module tb_current_sense_average_autorange_top;
   import csa_auto_pkg::*;

   localparam int     SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEFAULT;
   localparam int     CAL_ENTRIES       = CAL_ENTRIES_DEFAULT;
   localparam longint NA_MAX            = (longint'(1) <<< (NA_W - 1)) - 1;
   localparam longint NA_MIN            = -(longint'(1) <<< (NA_W - 1));
   localparam int     PIPE_SETTLE       = 8;     // result pipeline is five stages deep
   localparam int     END_SETTLE        = 20;
   localparam int     WATCHDOG_LIMIT    = 2000;  // quiet cycles before giving up
   localparam int     RANDOM_ITEMS      = 750;
   localparam int     RANDOM_CLOSES     = 40;

   // One input transfer, field for field.
   typedef struct {
      op_type             op;
      logic signed [15:0] high_sample;
      logic signed [15:0] low_sample;
      logic [11:0]        dac_code;
      logic [9:0]         cal_index;
      logic [15:0]        cal_high_value;
      logic [15:0]        cal_low_value;
   } sense_item_t;

   // One block result, field for field.
   typedef struct {
      logic [NA_W-1:0] dut_na;
      logic [NA_W-1:0] high_na;
      logic [NA_W-1:0] low_na;
      logic            range_low;
      logic            uncal;
   } block_reading_t;

   // Shadow of the eight configuration registers.
   typedef struct {
      logic                bypass;
      logic [11:0]         dac_min;
      logic [11:0]         dac_max;
      logic [11:0]         table_base;
      logic [31:0]         high_gain;
      logic [31:0]         low_gain;
      logic signed [20:0]  high_offset;
      logic [25:0]         switch_thresh;
   } sense_config_t;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [0:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;

   // Shadow state of the block, advanced on every accepted request.
   sense_config_t     cfg;
   logic [SUM_W-1:0]  high_acc = '0;
   logic [SUM_W-1:0]  low_acc  = '0;
   int                sample_cnt = 0;
   logic [15:0]       cal_high_ref [CAL_ENTRIES];
   logic [15:0]       cal_low_ref  [CAL_ENTRIES];
   bit                cal_written  [CAL_ENTRIES];
   int unsigned       written_slots[$];
   bit                range_low = 1'b0;
   longint            held_low_na = 0;
   int                blocks_closed = 0;

   block_reading_t    expected_readings[$];
   int                errors = 0;
   int                quiet_cycles = 0;
   bit                req_gaps_on = 1'b0;
   bit                rsp_stalls_on = 1'b0;
   int                rsp_hold = 0;

   current_sense_average_autorange_top #(
      .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
      .CAL_ENTRIES       (CAL_ENTRIES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // A code is calibrated when it sits inside [min, max), at or above the
   // table base, and its halved offset lands inside the table.
   function automatic bit dac_calibrated(input logic [11:0] dac);
      logic [11:0] off;
      off = dac - cfg.table_base;
      return dac < cfg.dac_max && dac >= cfg.dac_min && dac >= cfg.table_base
             && (off >> 1) < CAL_ENTRIES;
   endfunction

   // Q16.16 gain with round half up; the arithmetic shift gives the floor.
   function automatic longint scale_by_gain(input longint diff, input logic [31:0] gain);
      longint g;
      g = gain;
      return (diff * g + 32768) >>> 16;
   endfunction

   function automatic longint clamp_na(input longint v);
      if (v > NA_MAX) return NA_MAX;
      if (v < NA_MIN) return NA_MIN;
      return v;
   endfunction

   function automatic bit closes_block();
      return sample_cnt == SAMPLES_PER_BLOCK - 1;
   endfunction

   // Advance the shadow state by one accepted transfer; a block close
   // queues the reading the block must produce.
   task automatic average_and_range(input sense_item_t it);
      logic [11:0]    slot_off;
      int unsigned    slot;
      bit             uncal;
      longint         avg_high, avg_low, cal_h, cal_l, ofs, thr;
      longint         high_raw, high_na, low_na;
      block_reading_t rd;
      if (it.op == OP_CAL_WRITE) begin
         if (it.cal_index < CAL_ENTRIES) begin
            cal_high_ref[it.cal_index] = it.cal_high_value;
            cal_low_ref[it.cal_index]  = it.cal_low_value;
            if (!cal_written[it.cal_index]) written_slots.push_back(it.cal_index);
            cal_written[it.cal_index] = 1'b1;
         end
         return;
      end
      // +32768 offset is the sample with its sign bit flipped
      high_acc = high_acc + SUM_W'({~it.high_sample[15], it.high_sample[14:0]});
      low_acc  = low_acc  + SUM_W'({~it.low_sample[15], it.low_sample[14:0]});
      sample_cnt++;
      if (sample_cnt < SAMPLES_PER_BLOCK) return;

      slot_off = it.dac_code - cfg.table_base;
      slot     = slot_off >> 1;
      uncal    = !dac_calibrated(it.dac_code);
      if (uncal) begin
         high_raw = 0;
         low_na   = 0;
      end else begin
         avg_high = high_acc / SAMPLES_PER_BLOCK;
         avg_low  = low_acc / SAMPLES_PER_BLOCK;
         cal_h    = cal_high_ref[slot];
         cal_l    = cal_low_ref[slot];
         ofs      = cfg.high_offset;
         high_raw = scale_by_gain(avg_high - cal_h, cfg.high_gain) + ofs;
         low_na   = clamp_na(scale_by_gain(avg_low - cal_l, cfg.low_gain));
      end
      high_na = clamp_na(high_raw);
      thr     = cfg.switch_thresh;

      // Range decision uses the unclamped high current.
      if (cfg.bypass) begin
         range_low = 1'b0;
      end else if (high_raw <= thr) begin
         held_low_na = low_na;
         range_low   = 1'b1;
      end

      high_acc   = '0;
      low_acc    = '0;
      sample_cnt = 0;
      blocks_closed++;

      rd.dut_na    = range_low ? held_low_na[NA_W-1:0] : high_na[NA_W-1:0];
      rd.high_na   = high_na[NA_W-1:0];
      rd.low_na    = held_low_na[NA_W-1:0];
      rd.range_low = range_low;
      rd.uncal     = uncal;
      expected_readings.push_back(rd);
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic sense_item_t make_sample(input logic [15:0] hs, input logic [15:0] ls,
                                               input logic [11:0] dac);
      sense_item_t it;
      it.op             = OP_SAMPLE;
      it.high_sample    = hs;
      it.low_sample     = ls;
      it.dac_code       = dac;
      it.cal_index      = 10'($urandom);
      it.cal_high_value = 16'($urandom);
      it.cal_low_value  = 16'($urandom);
      return it;
   endfunction

   function automatic sense_item_t make_cal(input logic [9:0] ci, input logic [15:0] hv,
                                            input logic [15:0] lv);
      sense_item_t it;
      it.op             = OP_CAL_WRITE;
      it.high_sample    = 16'($urandom);
      it.low_sample     = 16'($urandom);
      it.dac_code       = 12'($urandom);
      it.cal_index      = ci;
      it.cal_high_value = hv;
      it.cal_low_value  = lv;
      return it;
   endfunction

   // Pick a closing code that reads a written entry; 0xfff is always
   // at or above the max code, so it is the safe fallback.
   function automatic logic [11:0] safe_close_dac();
      int          d;
      int unsigned slot;
      if (written_slots.size() == 0) return 12'hfff;
      for (int k = 0; k < 16; k++) begin
         slot = written_slots[$urandom_range(0, written_slots.size() - 1)];
         d    = cfg.table_base + 2 * slot + $urandom_range(0, 1);
         if (d <= 4095 && dac_calibrated(12'(d))) return 12'(d);
      end
      return 12'hfff;
   endfunction

   task automatic request_gap();
      int n;
      if (!req_gaps_on || $urandom_range(0, 99) >= 20) return;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Present one request and hold it until the transfer; valid stays high
   // so back-to-back items need no extra assignment.
   task automatic send_item(input sense_item_t it);
      // never let a closing sample read a table entry that was never written
      if (it.op == OP_SAMPLE && closes_block() && dac_calibrated(it.dac_code)
          && !cal_written[(12'(it.dac_code - cfg.table_base)) >> 1])
         it.dac_code = safe_close_dac();
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, it.cal_low_value, it.cal_high_value, it.cal_index,
                     it.dac_code, it.low_sample, it.high_sample};
      req_tuser  <= it.op;
      do @(posedge clock); while (!req_tready);
      average_and_range(it);
      request_gap();
   endtask

   task automatic send_block(input logic [15:0] hs, input logic [15:0] ls,
                             input logic [11:0] close_dac);
      for (int n = 0; n < SAMPLES_PER_BLOCK; n++)
         send_item(make_sample(hs, ls, (n == SAMPLES_PER_BLOCK - 1) ? close_dac
                                                                     : 12'($urandom)));
   endtask

   // Drop valid, drain every expected reading, then give the pipeline time
   // to finish anything that produces no reading.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_BYPASS_ON:      cfg.bypass        = value[0];
         CSR_DAC_MIN_CODE:   cfg.dac_min       = value[11:0];
         CSR_DAC_MAX_CODE:   cfg.dac_max       = value[11:0];
         CSR_DAC_TABLE_BASE: cfg.table_base    = value[11:0];
         CSR_HIGH_GAIN_Q16:  cfg.high_gain     = value;
         CSR_LOW_GAIN_Q16:   cfg.low_gain      = value;
         CSR_HIGH_OFFSET_NA: cfg.high_offset   = value[20:0];
         CSR_SWITCH_THRESH:  cfg.switch_thresh = value[25:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input sense_config_t c);
      wait_idle();
      write_csr(CSR_BYPASS_ON,      32'(c.bypass));
      write_csr(CSR_DAC_MIN_CODE,   32'(c.dac_min));
      write_csr(CSR_DAC_MAX_CODE,   32'(c.dac_max));
      write_csr(CSR_DAC_TABLE_BASE, 32'(c.table_base));
      write_csr(CSR_HIGH_GAIN_Q16,  c.high_gain);
      write_csr(CSR_LOW_GAIN_Q16,   c.low_gain);
      write_csr(CSR_HIGH_OFFSET_NA, 32'(c.high_offset));
      write_csr(CSR_SWITCH_THRESH,  32'(c.switch_thresh));
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] random_gain(input logic [31:0] nominal);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom;
         default: return nominal / 2 + $urandom_range(0, nominal);
      endcase
   endfunction

   function automatic sense_config_t random_config();
      sense_config_t c;
      c.bypass     = ($urandom_range(0, 3) == 0);
      c.table_base = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 600));
      c.dac_min    = ($urandom_range(0, 7) == 0) ? 12'($urandom)
                                                 : 12'($urandom_range(0, c.table_base + 100));
      c.dac_max    = ($urandom_range(0, 7) == 0) ? 12'($urandom)
                                                 : 12'($urandom_range(1800, 4095));
      c.high_gain  = random_gain(HIGH_GAIN_RESET);
      c.low_gain   = random_gain(LOW_GAIN_RESET);
      c.high_offset = $urandom_range(0, 1) ? 21'($urandom)
                                           : 21'(int'($urandom_range(0, 40000)) - 20000);
      case ($urandom_range(0, 9))
         0:       c.switch_thresh = '0;
         1:       c.switch_thresh = '1;
         2, 3, 4: c.switch_thresh = 26'($urandom);
         default: c.switch_thresh = 26'($urandom_range(0, 300000));
      endcase
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Load table corners, alternating patterns and a random spread.
   task automatic test_cal_table_load();
      send_item(make_cal(10'd0,    16'h0000, 16'h0000));
      send_item(make_cal(10'd1023, 16'hffff, 16'hffff));
      send_item(make_cal(10'h155,  16'h5555, 16'haaaa));
      send_item(make_cal(10'h2aa,  16'haaaa, 16'h5555));
      repeat (40) send_item(make_cal(10'($urandom), 16'($urandom), 16'($urandom)));
   endtask

   // Reset settings: bypass forces the high range. Full-scale samples in
   // both directions, then a table write landing mid-block on the very
   // entry that block reads at its close.
   task automatic test_bypass_extremes();
      send_block(16'sh7fff, 16'sh7fff, 12'd0);
      send_block(-16'sh8000, -16'sh8000, 12'd2046);
      for (int n = 0; n < SAMPLES_PER_BLOCK; n++) begin
         if (n == 20) send_item(make_cal(10'd5, 16'h1234, 16'hedcb));
         send_item(make_sample(n[0] ? 16'sh5555 : 16'haaaa, n[0] ? 16'haaaa : 16'sh5555,
                               (n == SAMPLES_PER_BLOCK - 1) ? 12'd10 : 12'($urandom)));
      end
   endtask

   // Every way a DAC code can fall outside the calibrated window.
   task automatic test_uncal_window();
      sense_config_t c;
      c = cfg;
      c.bypass     = 1'b0;
      c.dac_min    = 12'd100;
      c.dac_max    = 12'd3000;
      c.table_base = 12'd200;
      apply_config(c);
      send_block(16'sh1000, -16'sh1000, 12'd99);     // below min
      send_block(16'sh1000, -16'sh1000, 12'd3000);   // at max
      send_block(16'sh1000, -16'sh1000, 12'd150);    // below base, above min
      send_block(16'sh0000, 16'sh0000, 12'd200);     // first table entry, calibrated
      c.dac_min    = 12'd0;
      c.dac_max    = 12'd4095;
      c.table_base = 12'd0;
      apply_config(c);
      send_block(16'sh2000, 16'sh2000, 12'd2048);    // index past the table
      send_block(16'sh2000, 16'sh2000, 12'd2047);    // last table entry
      c.dac_min = 12'd4095;
      c.dac_max = 12'd0;
      apply_config(c);
      send_block(16'sh2000, 16'sh2000, 12'd1);       // empty window
   endtask

   // Gains at full scale drive both channels into the clamp; zero gain
   // leaves the offset alone so the threshold compare can hit equality.
   task automatic test_saturation_threshold();
      sense_config_t c;
      c.bypass        = 1'b0;
      c.dac_min       = 12'd0;
      c.dac_max       = 12'd4095;
      c.table_base    = 12'd0;
      c.high_gain     = '1;
      c.low_gain      = '1;
      c.high_offset   = 21'sd1048575;
      c.switch_thresh = '1;
      apply_config(c);
      send_block(16'sh7fff, 16'sh7fff, 12'd0);
      send_block(-16'sh8000, -16'sh8000, 12'd2046);
      c.high_offset   = -21'sd1048576;
      c.switch_thresh = '0;
      apply_config(c);
      send_block(16'sh0000, 16'sh7fff, 12'd1);
      c.high_gain     = '0;
      c.low_gain      = LOW_GAIN_RESET;
      c.high_offset   = 21'sd1000;
      c.switch_thresh = 26'd1000;
      apply_config(c);
      send_block(16'sh0100, 16'sh0400, 12'd0);       // equal to threshold: switch
      c.switch_thresh = 26'd999;
      apply_config(c);
      send_block(16'sh0100, -16'sh0400, 12'd0);      // one above: hold
   endtask

   // Phases of random settings. Most blocks sit near a level with small
   // noise so the range switch toggles; some are pure noise, and table
   // writes land anywhere inside a block.
   task automatic test_random_traffic();
      int          random_items;
      int          closes_goal;
      int          phase_items;
      int          mode;
      bit          noisy;
      logic [15:0] lvl_h, lvl_l, hs, ls, hv, lv;
      logic [11:0] dac;
      random_items = 0;
      closes_goal  = blocks_closed + RANDOM_CLOSES;
      noisy        = 1'b0;
      lvl_h        = '0;
      lvl_l        = '0;
      while (random_items < RANDOM_ITEMS || blocks_closed < closes_goal) begin
         apply_config(random_config());
         mode          = $urandom_range(0, 3);
         req_gaps_on   = mode[0];
         rsp_stalls_on <= mode[1];
         phase_items   = $urandom_range(120, 320);
         for (int n = 0; n < phase_items; n++) begin
            if ($urandom_range(0, 99) < 8) begin
               hv = $urandom_range(0, 1) ? 16'($urandom) : 16'(32768 + $urandom_range(0, 2047) - 1024);
               lv = $urandom_range(0, 1) ? 16'($urandom) : 16'(32768 + $urandom_range(0, 2047) - 1024);
               send_item(make_cal(10'($urandom), hv, lv));
            end else begin
               if (sample_cnt == 0) begin
                  noisy = ($urandom_range(0, 9) < 4);
                  lvl_h = 16'($urandom);
                  lvl_l = 16'($urandom);
               end
               hs  = noisy ? 16'($urandom) : 16'(lvl_h + $urandom_range(0, 511) - 256);
               ls  = noisy ? 16'($urandom) : 16'(lvl_l + $urandom_range(0, 511) - 256);
               dac = (closes_block() && $urandom_range(0, 3) != 0) ? safe_close_dac()
                                                                   : 12'($urandom);
               send_item(make_sample(hs, ls, dac));
            end
            random_items++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: random backpressure and checking
   // ------------------------------------------------------------------

   // Hold ready low for short stalls mostly, now and then a long one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 99) < 20) begin
         rsp_hold   <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic compare_field(input string field, input logic [NA_W-1:0] want,
                                input logic [NA_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
   endtask

   // Compare each result transfer with the oldest expected reading.
   always @(posedge clock) begin : check_readings
      block_reading_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transfer, expected none, actual tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = expected_readings.pop_front();
            compare_field("dut_current_na",  want.dut_na,    rsp_tdata[NA_W-1:0]);
            compare_field("high_current_na", want.high_na,   rsp_tdata[2*NA_W-1:NA_W]);
            compare_field("low_current_na",  want.low_na,    rsp_tdata[3*NA_W-1:2*NA_W]);
            compare_field("range_is_low",    27'(want.range_low), 27'(rsp_tuser[0]));
            compare_field("uncalibrated",    27'(want.uncal),     27'(rsp_tuser[1]));
         end
      end
   end

   // End the run when nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_current_sense_average_autorange_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      cfg.bypass        = 1'b1;
      cfg.dac_min       = '0;
      cfg.dac_max       = DAC_MAX_RESET;
      cfg.table_base    = '0;
      cfg.high_gain     = HIGH_GAIN_RESET;
      cfg.low_gain      = LOW_GAIN_RESET;
      cfg.high_offset   = HIGH_OFFSET_RESET;
      cfg.switch_thresh = THRESH_RESET;
      foreach (cal_written[i]) cal_written[i] = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part with light idling on both sides
      req_gaps_on   = 1'b1;
      rsp_stalls_on <= 1'b1;
      test_cal_table_load();
      test_bypass_extremes();
      test_uncal_window();
      test_saturation_threshold();
      test_random_traffic();

      // drain, then let any late transfer show up
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);
      if (errors == 0)
         $display("tb_current_sense_average_autorange_top passed");
      else
         $display("tb_current_sense_average_autorange_top failed");
      $finish;
   end

endmodule
